// File: design/qwsct_pkg.sv
package qwsct_pkg;

	// Field widths.
	localparam int ANGLE_W = 32;
	localparam int SINE_W = 16;
	localparam int TAN_W = 37;

	// Quarter-wave table geometry.
	localparam int TABLE_ENTRIES = 1000;
	localparam int IDX_W = 10;
	localparam int TAB_W = 15;

	// Angle constants in Q23.8 degrees.
	localparam logic [16:0] FULL_TURN = 17'd92160;
	localparam logic [16:0] QUARTER_TURN = 17'd23040;
	localparam logic [16:0] HALF_TURN = 17'd46080;
	localparam logic [16:0] THREE_QUARTER = 17'd69120;
	// Offset of 2^31 modulo a full turn, used to undo the sign bias.
	localparam logic [16:0] BIAS_MOD = 17'd63488;

	// Reciprocal of a full turn for the modulo reduction.
	localparam int RECIP_SHIFT = 48;
	localparam longint unsigned RECIP_L = ((64'd1 << RECIP_SHIFT) + 64'd92159) / 64'd92160;
	localparam logic [31:0] RECIP = RECIP_L[31:0];

	// Reciprocal of nine for the index scaling: idx = floor(v * 25 / 576).
	localparam longint unsigned DIV9_L = ((64'd1 << 17) + 64'd8) / 64'd9;
	localparam logic [13:0] DIV9 = DIV9_L[13:0];

	// Tangent when the cosine sample is zero: 1000000 in Q16.16.
	localparam logic [TAN_W-1:0] TAN_INF = 37'd65536000000;

	// Divider depth: one quotient bit per stage.
	localparam int QUO_W = 32;

	// Taylor series denominators (2k)(2k+1) for k = 1 to 12.
	localparam longint unsigned TAYLOR_DEN [12] = '{64'd6, 64'd20, 64'd42, 64'd72,
		64'd110, 64'd156, 64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600};

	typedef logic [TAB_W-1:0] tab_t [TABLE_ENTRIES];

	// Sine and cosine samples handed from front to back.
	typedef struct packed {
		logic signed [SINE_W-1:0] sine;
		logic signed [SINE_W-1:0] cosine;
	} sc_t;

	// Folded angle and its sign.
	typedef struct packed {
		logic [14:0] v;
		logic neg;
	} fold_t;

	// Builds the sine samples with a Q30 Taylor series.
	function automatic tab_t build_table();
		tab_t tab;
		longint unsigned x, x2, term, pos, neg, val;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			x = longint'(i) * 64'd1686629713 / 64'd1000;
			x2 = (x * x) >> 30;
			term = x;
			pos = x;
			neg = 0;
			for (int k = 1; k <= 12; k++) begin
				term = ((term * x2) >> 30) / TAYLOR_DEN[k-1];
				if (k % 2 == 1) begin
					neg = neg + term;
				end else begin
					pos = pos + term;
				end
			end
			val = (pos >= neg) ? pos - neg : 64'd0;
			val = (val + (64'd1 << 14)) >> 15;
			if (val > 64'd32767) begin
				val = 64'd32767;
			end
			tab[i] = val[TAB_W-1:0];
		end
		return tab;
	endfunction

	localparam tab_t SINE_TAB = build_table();

endpackage

// File: design/qwsct_front.sv
module qwsct_front import qwsct_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [ANGLE_W-1:0] angle,
	output logic out_valid,
	input  logic out_ready,
	output sc_t out_sc
);

	logic en;
	logic [6:1] v_q;

	logic [31:0] u_s1;
	logic [15:0] q_s1;
	logic [16:0] r_s2;
	logic [16:0] r_s3;
	fold_t fs_s4, fc_s4;
	logic [IDX_W-1:0] is_s5, ic_s5;
	logic ns_s5, nc_s5;
	logic [TAB_W-1:0] ts_s6, tc_s6;
	logic ns_s6, nc_s6;

	// Folds a reduced angle onto the first quadrant.
	function automatic fold_t fold(input logic [16:0] r);
		fold_t f;
		if (r <= QUARTER_TURN) begin
			f.v = r[14:0]; f.neg = 1'b0;
		end else if (r <= HALF_TURN) begin
			f.v = 15'(HALF_TURN - r); f.neg = 1'b0;
		end else if (r <= THREE_QUARTER) begin
			f.v = 15'(r - HALF_TURN); f.neg = 1'b1;
		end else begin
			f.v = 15'(FULL_TURN - r); f.neg = 1'b1;
		end
		return f;
	endfunction

	// Table index floor(v * 1000 / 23040), clamped to the last entry.
	function automatic logic [IDX_W-1:0] index_of(input logic [14:0] v);
		logic [19:0] p;
		logic [27:0] m;
		logic [10:0] idx;
		p = 20'(v) * 20'd25;
		m = 28'(p[19:6]) * 28'(DIV9);
		idx = m[27:17];
		if (idx >= 11'(TABLE_ENTRIES)) begin
			idx = 11'(TABLE_ENTRIES - 1);
		end
		return idx[IDX_W-1:0];
	endfunction

	assign en = !v_q[6] || out_ready;
	assign in_ready = en;
	assign out_valid = v_q[6];

	// Valid bits follow the items through the stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[5:1], in_valid};
		end
	end

	// Stage 1: bias to unsigned and estimate the number of full turns.
	logic [31:0] u_in;
	logic [63:0] prod;
	assign u_in = {~angle[31], angle[30:0]};
	assign prod = 64'(u_in) * 64'(RECIP);

	// Stage 2: remainder, fixing an estimate that is one too high.
	logic signed [34:0] r0;
	assign r0 = $signed({3'b0, u_s1}) - $signed({2'b0, 33'(q_s1) * 33'(FULL_TURN)});

	// Stage 3: remove the bias remainder.
	logic [17:0] d3;
	assign d3 = {1'b0, r_s2} - {1'b0, BIAS_MOD};

	// Stage 4: cosine angle is a quarter turn on.
	logic [17:0] rc;
	logic [16:0] rc_w;
	assign rc = {1'b0, r_s3} + {1'b0, QUARTER_TURN};
	assign rc_w = (rc >= {1'b0, FULL_TURN}) ? 17'(rc - {1'b0, FULL_TURN}) : rc[16:0];

	always_ff @(posedge clk) begin
		if (en) begin
			u_s1 <= u_in;
			q_s1 <= prod[63:48];
			r_s2 <= (r0 < 0) ? 17'(r0 + 35'(FULL_TURN)) : r0[16:0];
			r_s3 <= d3[17] ? 17'(d3 + {1'b0, FULL_TURN}) : d3[16:0];
			fs_s4 <= fold(r_s3);
			fc_s4 <= fold(rc_w);
			is_s5 <= index_of(fs_s4.v);
			ic_s5 <= index_of(fc_s4.v);
			ns_s5 <= fs_s4.neg;
			nc_s5 <= fc_s4.neg;
			ts_s6 <= SINE_TAB[is_s5];
			tc_s6 <= SINE_TAB[ic_s5];
			ns_s6 <= ns_s5;
			nc_s6 <= nc_s5;
		end
	end

	// Apply the quadrant sign; a negated zero stays zero.
	assign out_sc.sine = ns_s6 ? -$signed({1'b0, ts_s6}) : $signed({1'b0, ts_s6});
	assign out_sc.cosine = nc_s6 ? -$signed({1'b0, tc_s6}) : $signed({1'b0, tc_s6});

endmodule

// File: design/qwsct_queue.sv
module qwsct_queue import qwsct_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_ready,
	input  sc_t  wr_data,
	output logic rd_valid,
	input  logic rd_ready,
	output sc_t  rd_data
);

	sc_t mem_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic do_wr, do_rd;

	assign wr_ready = (cnt_q != 3'd4);
	assign rd_valid = (cnt_q != 3'd0);
	assign do_wr = wr_valid && wr_ready;
	assign do_rd = rd_valid && rd_ready;
	assign rd_data = mem_q[rp_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) wp_q <= wp_q + 2'd1;
			if (do_rd) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + 3'(do_wr) - 3'(do_rd);
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wr_data;
		end
	end

endmodule

// File: design/qwsct_back.sv
module qwsct_back import qwsct_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sc_t  in_sc,
	output logic empty,
	input  logic pop,
	output logic signed [SINE_W-1:0] sine,
	output logic signed [SINE_W-1:0] cosine,
	output logic signed [TAN_W-1:0] tangent
);

	logic en;
	logic v_q [QUO_W+1];
	logic [14:0] rem_s [QUO_W+1];
	logic [31:0] num_s [QUO_W+1];
	logic [31:0] quo_s [QUO_W+1];
	logic [14:0] cm_s [QUO_W+1];
	sc_t sc_s [QUO_W+1];
	logic flip_s [QUO_W+1];
	logic czero_s [QUO_W+1];

	// Two-entry output buffer.
	typedef struct packed {
		sc_t sc;
		logic [TAN_W-1:0] tan;
	} res_t;
	res_t ob_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic ob_full, do_wr, do_rd;

	assign ob_full = (cnt_q == 2'd2);
	assign en = !v_q[QUO_W] || !ob_full;
	assign in_ready = en;

	// Magnitudes and rounded dividend of the incoming request.
	logic [15:0] sm, cm;
	logic [31:0] dividend;
	assign sm = in_sc.sine[15] ? 16'(-in_sc.sine) : in_sc.sine;
	assign cm = in_sc.cosine[15] ? 16'(-in_sc.cosine) : in_sc.cosine;
	assign dividend = {sm, 16'd0} + 32'(cm[15:1]);

	// Valid bits of the divider stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= QUO_W; k++) v_q[k] <= 1'b0;
		end else if (en) begin
			v_q[0] <= in_valid;
			for (int k = 1; k <= QUO_W; k++) v_q[k] <= v_q[k-1];
		end
	end

	// Restoring divider, one quotient bit per stage.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= '0;
			num_s[0] <= dividend;
			quo_s[0] <= '0;
			cm_s[0] <= cm[14:0];
			sc_s[0] <= in_sc;
			flip_s[0] <= in_sc.sine[15] ^ in_sc.cosine[15];
			czero_s[0] <= (in_sc.cosine == '0);
			for (int k = 1; k <= QUO_W; k++) begin
				logic [15:0] trial;
				trial = {rem_s[k-1], num_s[k-1][31]};
				if (trial >= {1'b0, cm_s[k-1]}) begin
					rem_s[k] <= 15'(trial - {1'b0, cm_s[k-1]});
					quo_s[k] <= {quo_s[k-1][30:0], 1'b1};
				end else begin
					rem_s[k] <= trial[14:0];
					quo_s[k] <= {quo_s[k-1][30:0], 1'b0};
				end
				num_s[k] <= {num_s[k-1][30:0], 1'b0};
				cm_s[k] <= cm_s[k-1];
				sc_s[k] <= sc_s[k-1];
				flip_s[k] <= flip_s[k-1];
				czero_s[k] <= czero_s[k-1];
			end
		end
	end

	// Signed tangent of the last stage.
	logic [TAN_W-1:0] tan_w;
	always_comb begin
		if (czero_s[QUO_W]) begin
			tan_w = TAN_INF;
		end else if (flip_s[QUO_W]) begin
			tan_w = -(TAN_W'(quo_s[QUO_W]));
		end else begin
			tan_w = TAN_W'(quo_s[QUO_W]);
		end
	end

	assign do_wr = v_q[QUO_W] && en;
	assign do_rd = pop && !empty;
	assign empty = (cnt_q == 2'd0);

	// Output buffer control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (do_wr) wp_q <= !wp_q;
			if (do_rd) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(do_wr) - 2'(do_rd);
		end
	end

	// Output buffer storage.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			ob_q[wp_q] <= '{sc: sc_s[QUO_W], tan: tan_w};
		end
	end

	assign sine = ob_q[rp_q].sc.sine;
	assign cosine = ob_q[rp_q].sc.cosine;
	assign tangent = $signed(ob_q[rp_q].tan);

endmodule

// File: design/quarter_wave_sine_cosine_tangent.sv
// Sine, cosine and tangent of a Q23.8 angle in degrees, by quarter-wave table.
// Input channel: present angle with push; a request is taken on a rising edge
// with push high and full low. Output channel: while empty is low the oldest
// result (sine and cosine in Q1.15, tangent in Q16.16) is on the ports, and
// it is taken on a rising edge with pop high.
// The front end reduces the angle modulo 360 degrees with a reciprocal
// multiply, folds it by quadrant and reads the 1000-entry sine table for
// sine and cosine. A four-entry queue follows. The
// back end is a 32-stage restoring divider, one quotient bit per stage, that
// forms the tangent, then a two-entry output buffer.
// In steady state, while results are popped, one request is taken per cycle.
// When the receiver stops popping, the output buffer, divider, queue and
// front end fill in turn and full then rises; nothing is dropped.
// Reset clears all valid bits and pointers: the block comes up empty and
// ready, with no table load needed.
module quarter_wave_sine_cosine_tangent import qwsct_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  logic signed [ANGLE_W-1:0] angle,
	output logic empty,
	input  logic pop,
	output logic signed [SINE_W-1:0] sine,
	output logic signed [SINE_W-1:0] cosine,
	output logic signed [TAN_W-1:0] tangent
);

	logic in_ready;
	logic f_valid, f_ready, b_valid, b_ready;
	sc_t f_sc, b_sc;

	assign full = !in_ready;

	// Angle reduction, folding and table read.
	qwsct_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(push), .in_ready(in_ready), .angle(angle),
		.out_valid(f_valid), .out_ready(f_ready), .out_sc(f_sc)
	);

	// Queue between the two halves.
	qwsct_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_sc),
		.rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_sc)
	);

	// Tangent division and output buffer.
	qwsct_back u_back (
		.clk(clk), .arst_n(arst_n),
		.in_valid(b_valid), .in_ready(b_ready), .in_sc(b_sc),
		.empty(empty), .pop(pop),
		.sine(sine), .cosine(cosine), .tangent(tangent)
	);

endmodule
